[hw/rtl/pcdl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdl_pkg
// Widths, register map, sequencer states and the symmetric clamp shared by
// the pid controller with dead band and error low-pass filter.
// ----------------------------------------------------------------------------
package pcdl_pkg;

  // field and datapath widths
  localparam int unsigned DataW  = 32;  // Q16.16 samples and state
  localparam int unsigned GainW  = 24;  // Q8.16 gains
  localparam int unsigned LimitW = 31;  // Q16.16 magnitudes
  localparam int unsigned RatioW = 17;  // Q1.16 filter ratio
  localparam int unsigned FracW  = 16;  // fraction bits dropped after a product
  localparam int unsigned OpAW   = DataW + 1;        // signed operand, holds ef - prev
  localparam int unsigned OpBW   = GainW + 1;        // non-negative operand as signed
  localparam int unsigned ProdW  = OpAW + OpBW;      // full product
  localparam int unsigned TermW  = ProdW - FracW;    // product in Q16.16
  localparam int unsigned AccW   = 50;               // blend sum and drive sum
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned PaddrW  = RegIdxW + 2;

  localparam logic [RatioW-1:0] RatioOne = RatioW'(17'h10000);

  // configuration register map, word index
  typedef enum logic [RegIdxW-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INT_LIMIT = 3'd3,
    REG_OUT_LIMIT = 3'd4,
    REG_DEAD_BAND = 3'd5,
    REG_RATIO     = 3'd6
  } reg_idx_e;

  // sequencer states
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_ERR   = 10'b00_0000_0010,
    ST_MUL_E = 10'b00_0000_0100,
    ST_MUL_R = 10'b00_0000_1000,
    ST_BLEND = 10'b00_0001_0000,
    ST_MUL_I = 10'b00_0010_0000,
    ST_MUL_D = 10'b00_0100_0000,
    ST_MUL_P = 10'b00_1000_0000,
    ST_SUM   = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_e;

  // clamp a wide signed value to +/- lim
  function automatic logic signed [DataW-1:0] clamp_sym(
    input logic signed [AccW-1:0] x,
    input logic [LimitW-1:0]      lim
  );
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    logic signed [AccW-1:0] res;
    hi = $signed({{(AccW-LimitW){1'b0}}, lim});
    lo = -hi;
    if (x > hi) begin
      res = hi;
    end else if (x < lo) begin
      res = lo;
    end else begin
      res = x;
    end
    return res[DataW-1:0];
  endfunction

endpackage

[hw/rtl/pcdl_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdl_mul
// Shared signed multiplier with a registered product, used on each multiply
// step of the sequencer.
// ----------------------------------------------------------------------------
module pcdl_mul
  import pcdl_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [OpAW-1:0]  a_i,
  input  logic signed [OpBW-1:0]  b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  // product register, loaded only on multiply steps
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

[hw/rtl/pid_controller_deadzone_lpf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_deadzone_lpf
// Positional pid controller with error dead band and error low-pass blend,
// built around one shared multiplier stepped by a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  request  | in_valid_i, in_stall_o, action_i,         | in
//           | setpoint_i, measured_i                    |
//  result   | out_valid_o, out_stall_i, drive_o         | out
//  config   | psel, penable, pwrite, paddr, pwdata,     | in/out
//           | prdata, pready                            |
//
//  a compute request runs eight sequencer steps around the shared multiplier
//  (ERR, MUL_E, MUL_R, BLEND, MUL_I, MUL_D, MUL_P, SUM) after acceptance,
//  then shows a valid result; a clear shows its result in the next cycle
//  in_stall_o is high from acceptance until the result has been taken, so a
//  new request is accepted at the earliest in the cycle after the result leaves
//  the result holds on drive_o while out_stall_i is high
//  reset clears the state, the sequencer and the registers (ratio to one)
// ----------------------------------------------------------------------------
module pid_controller_deadzone_lpf
  import pcdl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic signed [DataW-1:0]  setpoint_i,
  input  logic signed [DataW-1:0]  measured_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DataW-1:0]  drive_o,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PaddrW-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  state_e state_q, state_d;

  logic [GainW-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [LimitW-1:0] int_limit_q, out_limit_q, dead_band_q;
  logic [RatioW-1:0] ratio_q;

  logic signed [DataW-1:0] sp_q, ms_q;
  logic signed [DataW-1:0] err_q;
  logic [RatioW-1:0]       r_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [DataW-1:0] ef_q;
  logic signed [OpAW-1:0]  dlt_q;
  logic signed [DataW-1:0] filt_q;
  logic signed [DataW-1:0] integ_q;
  logic signed [DataW-1:0] drive_q;

  logic                    in_acc;
  logic                    cfg_we;
  logic signed [DataW:0]   diff;
  logic [DataW:0]          mag;
  logic                    in_band;
  logic signed [DataW-1:0] err_sat;
  logic                    mul_en;
  logic signed [OpAW-1:0]  mul_a;
  logic signed [OpBW-1:0]  mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [TermW-1:0] term;
  logic signed [AccW-1:0]  term_x;
  logic signed [AccW-1:0]  blend_sum;
  logic signed [AccW-1:0]  integ_sum;
  logic signed [AccW-1:0]  drive_sum;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign drive_o     = drive_q;

  // configuration writes
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      int_limit_q <= '0;
      out_limit_q <= '0;
      dead_band_q <= '0;
      ratio_q     <= RatioOne;
    end else if (cfg_we) begin
      unique case (paddr[PaddrW-1:2])
        REG_GAIN_P:    gain_p_q    <= pwdata[GainW-1:0];
        REG_GAIN_I:    gain_i_q    <= pwdata[GainW-1:0];
        REG_GAIN_D:    gain_d_q    <= pwdata[GainW-1:0];
        REG_INT_LIMIT: int_limit_q <= pwdata[LimitW-1:0];
        REG_OUT_LIMIT: out_limit_q <= pwdata[LimitW-1:0];
        REG_DEAD_BAND: dead_band_q <= pwdata[LimitW-1:0];
        REG_RATIO:     ratio_q     <= pwdata[RatioW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[PaddrW-1:2])
      REG_GAIN_P:    prdata = 32'(gain_p_q);
      REG_GAIN_I:    prdata = 32'(gain_i_q);
      REG_GAIN_D:    prdata = 32'(gain_d_q);
      REG_INT_LIMIT: prdata = 32'(int_limit_q);
      REG_OUT_LIMIT: prdata = 32'(out_limit_q);
      REG_DEAD_BAND: prdata = 32'(dead_band_q);
      REG_RATIO:     prdata = 32'(ratio_q);
      default:       prdata = '0;
    endcase
  end

  // error with dead band and saturation
  assign diff    = {sp_q[DataW-1], sp_q} - {ms_q[DataW-1], ms_q};
  assign mag     = diff[DataW] ? (DataW+1)'(-diff) : diff;
  assign in_band = mag < {2'b00, dead_band_q};

  always_comb begin
    if (diff[DataW] != diff[DataW-1]) begin
      err_sat = diff[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      err_sat = diff[DataW-1:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_MUL_E: begin
        mul_a = {err_q[DataW-1], err_q};
        mul_b = $signed({{(OpBW-RatioW){1'b0}}, r_q});
      end
      ST_MUL_R: begin
        mul_a = {filt_q[DataW-1], filt_q};
        mul_b = $signed({{(OpBW-RatioW){1'b0}}, RatioOne - r_q});
      end
      ST_MUL_I: begin
        mul_a = {ef_q[DataW-1], ef_q};
        mul_b = $signed({1'b0, gain_i_q});
      end
      ST_MUL_D: begin
        mul_a = dlt_q;
        mul_b = $signed({1'b0, gain_d_q});
      end
      ST_MUL_P: begin
        mul_a = {ef_q[DataW-1], ef_q};
        mul_b = $signed({1'b0, gain_p_q});
      end
      default: mul_en = 1'b0;
    endcase
  end

  pcdl_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // product back to Q16.16, floor rounding
  assign term      = prod[ProdW-1:FracW];
  assign term_x    = {{(AccW-TermW){term[TermW-1]}}, term};
  assign blend_sum = acc_q + prod[AccW-1:0];
  assign integ_sum = {{(AccW-DataW){integ_q[DataW-1]}}, integ_q} + term_x;
  assign drive_sum = acc_q + term_x;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = action_i ? ST_DONE : ST_ERR;
      ST_ERR:   state_d = ST_MUL_E;
      ST_MUL_E: state_d = ST_MUL_R;
      ST_MUL_R: state_d = ST_BLEND;
      ST_BLEND: state_d = ST_MUL_I;
      ST_MUL_I: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_MUL_P;
      ST_MUL_P: state_d = ST_SUM;
      ST_SUM:   state_d = ST_DONE;
      ST_DONE:  if (!out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // controller state and drive
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q  <= '0;
      integ_q <= '0;
      drive_q <= '0;
    end else begin
      if (in_acc && action_i) begin
        filt_q  <= '0;
        integ_q <= '0;
        drive_q <= '0;
      end
      if (state_q == ST_MUL_D) begin
        integ_q <= clamp_sym(integ_sum, int_limit_q);
        filt_q  <= ef_q;
      end
      if (state_q == ST_SUM) begin
        drive_q <= clamp_sym(drive_sum, out_limit_q);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sp_q <= setpoint_i;
      ms_q <= measured_i;
    end
    if (state_q == ST_ERR) begin
      err_q <= in_band ? '0 : err_sat;
      r_q   <= (ratio_q > RatioOne) ? RatioOne : ratio_q;
    end
    if (state_q == ST_MUL_R) begin
      acc_q <= prod[AccW-1:0];
    end
    if (state_q == ST_BLEND) begin
      ef_q <= blend_sum[FracW +: DataW];
    end
    if (state_q == ST_MUL_I) begin
      dlt_q <= {ef_q[DataW-1], ef_q} - {filt_q[DataW-1], filt_q};
    end
    if (state_q == ST_MUL_P) begin
      acc_q <= term_x + {{(AccW-DataW){integ_q[DataW-1]}}, integ_q};
    end
  end

  // checks
  a_busy_while_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result pending while requests are open");

  a_clear_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && action_i |=> out_valid_o && (drive_o == '0))
    else $error("clear did not answer zero");

  a_step_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !action_i |-> ##9 out_valid_o)
    else $error("compute step result not ready after nine cycles");

  a_no_early_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !action_i |=> !out_valid_o)
    else $error("result shown before the steps ran");

endmodule
